/* hw/rtl/cth_pkg.sv */
`timescale 1ns / 1ps

package cth_pkg;

    localparam logic [2:0] CMD_OPEN       = 3'd0;
    localparam logic [2:0] CMD_CONNECT    = 3'd1;
    localparam logic [2:0] CMD_DISCONNECT = 3'd2;
    localparam logic [2:0] CMD_CLOSE      = 3'd3;
    localparam logic [2:0] CMD_RX         = 3'd4;
    localparam logic [2:0] CMD_TICK       = 3'd5;

    localparam logic [1:0] ST_CLOSED    = 2'd0;
    localparam logic [1:0] ST_SYNSENT   = 2'd1;
    localparam logic [1:0] ST_CONNECTED = 2'd2;
    localparam logic [1:0] ST_FINWAIT   = 2'd3;

    localparam logic [1:0] SEG_SYN    = 2'd0;
    localparam logic [1:0] SEG_SYNACK = 2'd1;
    localparam logic [1:0] SEG_FIN    = 2'd2;
    localparam logic [1:0] SEG_FINACK = 2'd3;

    localparam logic [1:0] KIND_REPLY = 2'd0;
    localparam logic [1:0] KIND_SEG   = 2'd1;
    localparam logic [1:0] KIND_EVENT = 2'd2;

    localparam logic [1:0] EV_CONNECTED = 2'd0;
    localparam logic [1:0] EV_FINACK    = 2'd1;
    localparam logic [1:0] EV_SYN_FAIL  = 2'd2;
    localparam logic [1:0] EV_FIN_FAIL  = 2'd3;

    localparam logic [1:0] REG_SYN_TIMEOUT = 2'd0;
    localparam logic [1:0] REG_SYN_RETRY   = 2'd1;
    localparam logic [1:0] REG_FIN_TIMEOUT = 2'd2;
    localparam logic [1:0] REG_FIN_RETRY   = 2'd3;

    localparam int MAX_OUT = 16;

    // Controller to datapath.
    typedef struct packed {
        logic latch;    // capture the command beat
        logic visit;    // process the entry at the scan index
        logic direct;   // process the addressed slot (connect/disconnect/close)
        logic finish;   // finish open: allocate or fail
        logic scan_clr; // reset scan index
    } cth_ctl_t;

    // Datapath to controller.
    typedef struct packed {
        logic scan_done;
        logic stop;     // open or receive lookup found its answer
    } cth_sts_t;

endpackage

/* hw/rtl/cth_ctrl.sv */
`timescale 1ns / 1ps

module cth_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [2:0]        cmd,
    output logic              busy,
    output cth_pkg::cth_ctl_t ctl,
    input  cth_pkg::cth_sts_t sts
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_DIRECT = 2'd2;
    localparam logic [1:0] S_FINISH = 2'd3;

    logic [1:0] state_reg, state_next;
    logic [2:0] cmd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cmd_reg   <= 3'd0;
        end
        else
        begin
            state_reg <= state_next;
            if (start && state_reg == S_IDLE)
            begin
                cmd_reg <= cmd;
            end
        end
    end

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        ctl          = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    ctl.latch    = 1'b1;
                    ctl.scan_clr = 1'b1;
                    if (cmd inside {cth_pkg::CMD_OPEN, cth_pkg::CMD_RX, cth_pkg::CMD_TICK})
                    begin
                        state_next = S_SCAN;
                    end
                    else if (cmd inside {cth_pkg::CMD_CONNECT, cth_pkg::CMD_DISCONNECT,
                                         cth_pkg::CMD_CLOSE})
                    begin
                        state_next = S_DIRECT;
                    end
                end
            end
            S_SCAN:
            begin
                ctl.visit = 1'b1;
                if (sts.stop)
                begin
                    state_next = S_IDLE;
                end
                else if (sts.scan_done)
                begin
                    state_next = (cmd_reg == cth_pkg::CMD_OPEN) ? S_FINISH : S_IDLE;
                end
            end
            S_DIRECT:
            begin
                ctl.direct = 1'b1;
                state_next = S_IDLE;
            end
            S_FINISH:
            begin
                ctl.finish = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

/* hw/rtl/cth_datapath.sv */
`timescale 1ns / 1ps

module cth_datapath #(
    parameter int NUM_CONNECTIONS = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  cth_pkg::cth_ctl_t ctl,
    output cth_pkg::cth_sts_t sts,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [15:0]       cfg_data,
    input  logic [2:0]        cmd,
    input  logic [2:0]        slot,
    input  logic [15:0]       local_port,
    input  logic [15:0]       remote_port,
    input  logic [15:0]       rx_dest_port,
    input  logic [2:0]        rx_seg_type,
    output logic              done,
    output logic [1:0]        out_kind,
    output logic              ok,
    output logic [2:0]        out_slot,
    output logic [1:0]        event_code,
    output logic [1:0]        tx_seg_type,
    output logic [15:0]       tx_src_port,
    output logic [15:0]       tx_dest_port,
    output logic              last
);

    localparam int IW = (NUM_CONNECTIONS > 1) ? $clog2(NUM_CONNECTIONS) : 1;
    localparam int CW = $clog2(NUM_CONNECTIONS + 1);
    localparam int NW = $clog2(cth_pkg::MAX_OUT + 1);

    logic [15:0] syn_to_reg, fin_to_reg;
    logic [3:0]  syn_rl_reg, fin_rl_reg;

    logic [NUM_CONNECTIONS-1:0] valid_reg;
    logic [1:0]  st_mem  [NUM_CONNECTIONS];
    logic [15:0] cp_mem  [NUM_CONNECTIONS];
    logic [15:0] sp_mem  [NUM_CONNECTIONS];
    logic [15:0] tm_mem  [NUM_CONNECTIONS];
    logic [3:0]  rl_mem  [NUM_CONNECTIONS];

    logic [2:0]  cmd_reg, slot_reg, stype_reg;
    logic [15:0] lport_reg, rport_reg, dport_reg;
    logic [CW-1:0] idx_reg;
    logic [NW-1:0] nout_reg;
    logic          free_found_reg;
    logic [IW-1:0] free_idx_reg;

    logic [IW-1:0] idx;
    logic [1:0]  e_st;
    logic        e_v;
    logic [15:0] e_tm;
    logic        e_syn;
    logic        here;
    logic [IW-1:0] sidx;

    assign idx   = idx_reg[IW-1:0];
    assign e_v   = valid_reg[idx];
    assign e_st  = st_mem[idx];
    assign e_tm  = tm_mem[idx];
    assign e_syn = (e_st == cth_pkg::ST_SYNSENT);
    assign sidx  = IW'(slot_reg);
    assign here  = (32'(slot_reg) < 32'(NUM_CONNECTIONS)) && valid_reg[sidx];

    logic is_last_scan;
    assign is_last_scan = (idx_reg == CW'(NUM_CONNECTIONS - 1));
    assign sts.scan_done = is_last_scan;

    logic match;
    assign match = e_v && (cp_mem[idx] == ((cmd_reg == cth_pkg::CMD_OPEN) ? lport_reg
                                                                          : dport_reg));
    assign sts.stop = match && (cmd_reg != cth_pkg::CMD_TICK);

    // Result staging: up to two results per cycle for connect/disconnect.
    logic        r0_v, r1_v;
    logic [1:0]  r0_kind, r0_code, r0_seg;
    logic        r0_ok;
    logic [2:0]  r0_slot;
    logic [15:0] r0_src, r0_dst;
    logic        r0_last;
    logic        r1_ok;
    logic        tick_last;

    // Last for ticks: no later entry that would still report, or this is the last result MAX_OUT allows.
    logic [NUM_CONNECTIONS-1:0] reporter;
    always_comb
    begin
        for (int k = 0; k < NUM_CONNECTIONS; k++)
        begin
            reporter[k] = valid_reg[k] &&
                          (st_mem[k] == cth_pkg::ST_SYNSENT ||
                           st_mem[k] == cth_pkg::ST_FINWAIT) &&
                          (tm_mem[k] <= 16'd1);
        end
    end
    logic [NUM_CONNECTIONS-1:0] later_mask;
    always_comb
    begin
        for (int k = 0; k < NUM_CONNECTIONS; k++)
        begin
            later_mask[k] = (k > int'(idx));
        end
    end
    assign tick_last = ((reporter & later_mask) == '0) ||
                       (nout_reg == NW'(cth_pkg::MAX_OUT - 1));

    always_comb
    begin
        r0_v = 1'b0; r1_v = 1'b0;
        r0_kind = cth_pkg::KIND_REPLY; r0_ok = 1'b0; r0_slot = 3'd0;
        r0_code = 2'd0; r0_seg = 2'd0; r0_src = 16'd0; r0_dst = 16'd0;
        r0_last = 1'b1; r1_ok = 1'b0;
        if (ctl.visit)
        begin
            if (cmd_reg == cth_pkg::CMD_OPEN)
            begin
                if (match)
                begin
                    r0_v = 1'b1;
                end
            end
            else if (cmd_reg == cth_pkg::CMD_RX)
            begin
                if (match && e_st == cth_pkg::ST_SYNSENT &&
                    stype_reg == {1'b0, cth_pkg::SEG_SYNACK})
                begin
                    r0_v = 1'b1; r0_kind = cth_pkg::KIND_EVENT; r0_ok = 1'b1;
                    r0_slot = 3'(idx_reg); r0_code = cth_pkg::EV_CONNECTED;
                end
                else if (match && e_st == cth_pkg::ST_FINWAIT &&
                         stype_reg == {1'b0, cth_pkg::SEG_FINACK})
                begin
                    r0_v = 1'b1; r0_kind = cth_pkg::KIND_EVENT; r0_ok = 1'b1;
                    r0_slot = 3'(idx_reg); r0_code = cth_pkg::EV_FINACK;
                end
            end
            else
            begin
                if (reporter[idx] && nout_reg < NW'(cth_pkg::MAX_OUT))
                begin
                    r0_v = 1'b1; r0_slot = 3'(idx_reg); r0_last = tick_last;
                    if (rl_mem[idx] != 4'd0)
                    begin
                        r0_kind = cth_pkg::KIND_SEG; r0_ok = 1'b1;
                        r0_seg = e_syn ? cth_pkg::SEG_SYN : cth_pkg::SEG_FIN;
                        r0_src = cp_mem[idx]; r0_dst = sp_mem[idx];
                    end
                    else
                    begin
                        r0_kind = cth_pkg::KIND_EVENT;
                        r0_code = e_syn ? cth_pkg::EV_SYN_FAIL : cth_pkg::EV_FIN_FAIL;
                    end
                end
            end
        end
        else if (ctl.finish)
        begin
            r0_v = 1'b1; r0_ok = free_found_reg;
            r0_slot = free_found_reg ? 3'(free_idx_reg) : 3'd0;
        end
        else if (ctl.direct)
        begin
            r0_slot = slot_reg;
            if (cmd_reg == cth_pkg::CMD_CONNECT && here &&
                st_mem[sidx] == cth_pkg::ST_CLOSED)
            begin
                r0_v = 1'b1; r0_kind = cth_pkg::KIND_SEG; r0_ok = 1'b1;
                r0_seg = cth_pkg::SEG_SYN; r0_src = cp_mem[sidx]; r0_dst = rport_reg;
                r0_last = 1'b0; r1_v = 1'b1; r1_ok = 1'b1;
            end
            else if (cmd_reg == cth_pkg::CMD_DISCONNECT && here &&
                     st_mem[sidx] == cth_pkg::ST_CONNECTED)
            begin
                r0_v = 1'b1; r0_kind = cth_pkg::KIND_SEG; r0_ok = 1'b1;
                r0_seg = cth_pkg::SEG_FIN; r0_src = cp_mem[sidx]; r0_dst = sp_mem[sidx];
                r0_last = 1'b0; r1_v = 1'b1; r1_ok = 1'b1;
            end
            else
            begin
                r0_v = 1'b1;
                r0_ok = (cmd_reg == cth_pkg::CMD_CLOSE) && here &&
                        (st_mem[sidx] == cth_pkg::ST_CLOSED);
            end
        end
    end

    logic       pend_reg;
    logic       pend_ok_reg;
    logic [2:0] pend_slot_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            syn_to_reg <= 16'd100; syn_rl_reg <= 4'd5;
            fin_to_reg <= 16'd100; fin_rl_reg <= 4'd5;
            valid_reg  <= '0;
            idx_reg    <= '0;
            nout_reg   <= '0;
            done       <= 1'b0;
            pend_reg   <= 1'b0;
            free_found_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    cth_pkg::REG_SYN_TIMEOUT: syn_to_reg <= cfg_data;
                    cth_pkg::REG_SYN_RETRY:   syn_rl_reg <= cfg_data[3:0];
                    cth_pkg::REG_FIN_TIMEOUT: fin_to_reg <= cfg_data;
                    cth_pkg::REG_FIN_RETRY:   fin_rl_reg <= cfg_data[3:0];
                    default: ;
                endcase
            end
            if (ctl.scan_clr)
            begin
                idx_reg <= '0; nout_reg <= '0; free_found_reg <= 1'b0;
            end
            else if (ctl.visit)
            begin
                idx_reg <= idx_reg + CW'(1);
                if (r0_v) nout_reg <= nout_reg + NW'(1);
                if (!e_v && !free_found_reg)
                begin
                    free_found_reg <= 1'b1;
                end
            end
            if (ctl.finish && free_found_reg)
            begin
                valid_reg[free_idx_reg] <= 1'b1;
            end
            if (ctl.direct && cmd_reg == cth_pkg::CMD_CLOSE && r0_ok)
            begin
                valid_reg[sidx] <= 1'b0;
            end
            done     <= r0_v || pend_reg;
            pend_reg <= r1_v;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.latch)
        begin
            cmd_reg <= cmd; slot_reg <= slot; stype_reg <= rx_seg_type;
            lport_reg <= local_port; rport_reg <= remote_port; dport_reg <= rx_dest_port;
        end
        if (ctl.visit && !e_v && !free_found_reg)
        begin
            free_idx_reg <= idx;
        end
        if (ctl.finish && free_found_reg)
        begin
            cp_mem[free_idx_reg] <= lport_reg;
            st_mem[free_idx_reg] <= cth_pkg::ST_CLOSED;
        end
        if (ctl.visit && cmd_reg == cth_pkg::CMD_RX && r0_v)
        begin
            st_mem[idx] <= (r0_code == cth_pkg::EV_CONNECTED) ? cth_pkg::ST_CONNECTED
                                                              : cth_pkg::ST_CLOSED;
        end
        if (ctl.visit && cmd_reg == cth_pkg::CMD_TICK && e_v &&
            (e_st == cth_pkg::ST_SYNSENT || e_st == cth_pkg::ST_FINWAIT))
        begin
            if (e_tm > 16'd1)
            begin
                tm_mem[idx] <= e_tm - 16'd1;
            end
            else if (rl_mem[idx] != 4'd0)
            begin
                rl_mem[idx] <= rl_mem[idx] - 4'd1;
                tm_mem[idx] <= e_syn ? syn_to_reg : fin_to_reg;
            end
            else
            begin
                st_mem[idx] <= cth_pkg::ST_CLOSED;
            end
        end
        if (ctl.direct && r1_v)
        begin
            if (cmd_reg == cth_pkg::CMD_CONNECT)
            begin
                sp_mem[sidx] <= rport_reg; st_mem[sidx] <= cth_pkg::ST_SYNSENT;
                tm_mem[sidx] <= syn_to_reg; rl_mem[sidx] <= syn_rl_reg;
            end
            else
            begin
                st_mem[sidx] <= cth_pkg::ST_FINWAIT;
                tm_mem[sidx] <= fin_to_reg; rl_mem[sidx] <= fin_rl_reg;
            end
        end
        pend_ok_reg   <= r1_ok;
        pend_slot_reg <= r0_slot;
        if (pend_reg)
        begin
            out_kind <= cth_pkg::KIND_REPLY; ok <= pend_ok_reg; out_slot <= pend_slot_reg;
            event_code <= 2'd0; tx_seg_type <= 2'd0; tx_src_port <= 16'd0;
            tx_dest_port <= 16'd0; last <= 1'b1;
        end
        else
        begin
            out_kind <= r0_kind; ok <= r0_ok; out_slot <= r0_slot; event_code <= r0_code;
            tx_seg_type <= r0_seg; tx_src_port <= r0_src; tx_dest_port <= r0_dst;
            last <= r0_last;
        end
    end

endmodule

/* hw/rtl/connection_table_handshake_fsm.sv */
`timescale 1ns / 1ps

// Channel   Ports                                         Beat
// command   start, busy, cmd, slot, local_port, ...       start && !busy
// result    done, out_kind, ok, out_slot, ..., last       done (one cycle)
// config    cfg_we, cfg_index, cfg_data                    cfg_we
//
// Open, receive and tick visit one entry a cycle until the scan ends or an open or receive
// lookup matches; an open that finds no match then takes a finish step that allocates or fails.
// Connect, disconnect and close go straight to the direct state without a scan.
// Each result is registered and shows in the cycle after its entry is handled, at most one a cycle;
// the reply after a SYN or FIN beat follows on the next cycle.
// Reset empties the table and loads the register defaults; the receiver cannot stall.

module connection_table_handshake_fsm #(
    parameter int NUM_CONNECTIONS = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  cmd,
    input  logic [2:0]  slot,
    input  logic [15:0] local_port,
    input  logic [15:0] remote_port,
    input  logic [15:0] rx_dest_port,
    input  logic [2:0]  rx_seg_type,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output logic        done,
    output logic [1:0]  out_kind,
    output logic        ok,
    output logic [2:0]  out_slot,
    output logic [1:0]  event_code,
    output logic [1:0]  tx_seg_type,
    output logic [15:0] tx_src_port,
    output logic [15:0] tx_dest_port,
    output logic        last
);

    cth_pkg::cth_ctl_t ctl;
    cth_pkg::cth_sts_t sts;

    cth_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(start), .cmd(cmd),
        .busy(busy), .ctl(ctl), .sts(sts)
    );

    cth_datapath #(.NUM_CONNECTIONS(NUM_CONNECTIONS)) u_dp (
        .clk(clk), .rst_n(rst_n), .ctl(ctl), .sts(sts),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .cmd(cmd), .slot(slot), .local_port(local_port), .remote_port(remote_port),
        .rx_dest_port(rx_dest_port), .rx_seg_type(rx_seg_type),
        .done(done), .out_kind(out_kind), .ok(ok), .out_slot(out_slot),
        .event_code(event_code), .tx_seg_type(tx_seg_type),
        .tx_src_port(tx_src_port), .tx_dest_port(tx_dest_port), .last(last)
    );

`ifndef ASSERT_OFF
    a_latch_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.latch |-> !busy)
        else $error("command captured while busy");
    a_one_phase: assert property (@(posedge clk) disable iff (!rst_n)
        $countones({ctl.visit, ctl.direct, ctl.finish}) <= 1)
        else $error("controller phases overlap");
    a_reply_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (done && out_kind == cth_pkg::KIND_SEG) |-> !last || $past(ctl.visit))
        else $error("direct segment marked last");
`endif

endmodule

/* tb/tb_connection_table_handshake_fsm.sv */
`timescale 1ns / 1ps

module tb_connection_table_handshake_fsm;

    localparam int NCONN = 8;
    localparam int IDLE_LIMIT = 5000;
    localparam int DRAIN_CYCLES = NCONN + 8;

    typedef struct packed {
        logic [1:0]  kind;
        logic        ok;
        logic [2:0]  slot;
        logic [1:0]  code;
        logic [1:0]  seg;
        logic [15:0] src;
        logic [15:0] dst;
        logic        last;
    } conn_result_t;

    class conn_scoreboard;
        logic [15:0] syn_to_ticks;
        logic [3:0]  syn_retries;
        logic [15:0] fin_to_ticks;
        logic [3:0]  fin_retries;
        logic        valid_q[NCONN];
        logic [1:0]  state_q[NCONN];
        logic [15:0] lport_q[NCONN];
        logic [15:0] rport_q[NCONN];
        logic [15:0] timer_q[NCONN];
        logic [3:0]  left_q[NCONN];
        conn_result_t pending[$];
        conn_result_t burst[$];
        int mismatches;

        function new();
            syn_to_ticks = 16'd100;
            syn_retries = 4'd5;
            fin_to_ticks = 16'd100;
            fin_retries = 4'd5;
            mismatches = 0;
            for (int i = 0; i < NCONN; i++) valid_q[i] = 1'b0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [15:0] data);
            case (idx)
                cth_pkg::REG_SYN_TIMEOUT: syn_to_ticks = data;
                cth_pkg::REG_SYN_RETRY:   syn_retries = data[3:0];
                cth_pkg::REG_FIN_TIMEOUT: fin_to_ticks = data;
                default:                  fin_retries = data[3:0];
            endcase
        endfunction

        function void add(logic [1:0] kind, logic ok, int idx, logic [1:0] code,
                          logic [1:0] seg, logic [15:0] src, logic [15:0] dst);
            conn_result_t r;
            r.kind = kind; r.ok = ok; r.slot = idx[2:0]; r.code = code;
            r.seg = seg; r.src = src; r.dst = dst; r.last = 1'b0;
            if (burst.size() < cth_pkg::MAX_OUT) burst.push_back(r);
        endfunction

        function void note_input(logic [2:0] c, logic [2:0] s, logic [15:0] lp,
                                 logic [15:0] rp, logic [15:0] dp, logic [2:0] st);
            int found;
            logic syn;
            burst.delete();
            case (c)
                cth_pkg::CMD_OPEN:
                begin
                    found = -1;
                    for (int i = 0; i < NCONN; i++)
                        if (valid_q[i] && lport_q[i] == lp) found = -2;
                    if (found == -1)
                        for (int i = NCONN - 1; i >= 0; i--)
                            if (!valid_q[i]) found = i;
                    if (found >= 0)
                    begin
                        valid_q[found] = 1'b1;
                        lport_q[found] = lp;
                        state_q[found] = cth_pkg::ST_CLOSED;
                        add(cth_pkg::KIND_REPLY, 1'b1, found, 2'd0, 2'd0, 16'd0, 16'd0);
                    end
                    else
                        add(cth_pkg::KIND_REPLY, 1'b0, 0, 2'd0, 2'd0, 16'd0, 16'd0);
                end
                cth_pkg::CMD_CONNECT:
                    if (valid_q[s] && state_q[s] == cth_pkg::ST_CLOSED)
                    begin
                        rport_q[s] = rp;
                        state_q[s] = cth_pkg::ST_SYNSENT;
                        timer_q[s] = syn_to_ticks;
                        left_q[s] = syn_retries;
                        add(cth_pkg::KIND_SEG, 1'b1, s, 2'd0, cth_pkg::SEG_SYN, lport_q[s], rp);
                        add(cth_pkg::KIND_REPLY, 1'b1, s, 2'd0, 2'd0, 16'd0, 16'd0);
                    end
                    else
                        add(cth_pkg::KIND_REPLY, 1'b0, s, 2'd0, 2'd0, 16'd0, 16'd0);
                cth_pkg::CMD_DISCONNECT:
                    if (valid_q[s] && state_q[s] == cth_pkg::ST_CONNECTED)
                    begin
                        state_q[s] = cth_pkg::ST_FINWAIT;
                        timer_q[s] = fin_to_ticks;
                        left_q[s] = fin_retries;
                        add(cth_pkg::KIND_SEG, 1'b1, s, 2'd0, cth_pkg::SEG_FIN, lport_q[s],
                            rport_q[s]);
                        add(cth_pkg::KIND_REPLY, 1'b1, s, 2'd0, 2'd0, 16'd0, 16'd0);
                    end
                    else
                        add(cth_pkg::KIND_REPLY, 1'b0, s, 2'd0, 2'd0, 16'd0, 16'd0);
                cth_pkg::CMD_CLOSE:
                    if (valid_q[s] && state_q[s] == cth_pkg::ST_CLOSED)
                    begin
                        valid_q[s] = 1'b0;
                        add(cth_pkg::KIND_REPLY, 1'b1, s, 2'd0, 2'd0, 16'd0, 16'd0);
                    end
                    else
                        add(cth_pkg::KIND_REPLY, 1'b0, s, 2'd0, 2'd0, 16'd0, 16'd0);
                cth_pkg::CMD_RX:
                begin
                    found = -1;
                    for (int i = NCONN - 1; i >= 0; i--)
                        if (valid_q[i] && lport_q[i] == dp) found = i;
                    if (found >= 0)
                    begin
                        if (state_q[found] == cth_pkg::ST_SYNSENT &&
                            st == {1'b0, cth_pkg::SEG_SYNACK})
                        begin
                            state_q[found] = cth_pkg::ST_CONNECTED;
                            add(cth_pkg::KIND_EVENT, 1'b1, found, cth_pkg::EV_CONNECTED, 2'd0,
                                16'd0, 16'd0);
                        end
                        else if (state_q[found] == cth_pkg::ST_FINWAIT &&
                                 st == {1'b0, cth_pkg::SEG_FINACK})
                        begin
                            state_q[found] = cth_pkg::ST_CLOSED;
                            add(cth_pkg::KIND_EVENT, 1'b1, found, cth_pkg::EV_FINACK, 2'd0,
                                16'd0, 16'd0);
                        end
                    end
                end
                cth_pkg::CMD_TICK:
                    for (int i = 0; i < NCONN; i++)
                    begin
                        if (valid_q[i] && (state_q[i] == cth_pkg::ST_SYNSENT ||
                                           state_q[i] == cth_pkg::ST_FINWAIT))
                        begin
                            syn = (state_q[i] == cth_pkg::ST_SYNSENT);
                            if (timer_q[i] > 16'd1)
                                timer_q[i] = timer_q[i] - 16'd1;
                            else if (left_q[i] > 4'd0)
                            begin
                                left_q[i] = left_q[i] - 4'd1;
                                timer_q[i] = syn ? syn_to_ticks : fin_to_ticks;
                                add(cth_pkg::KIND_SEG, 1'b1, i, 2'd0,
                                    syn ? cth_pkg::SEG_SYN : cth_pkg::SEG_FIN,
                                    lport_q[i], rport_q[i]);
                            end
                            else
                            begin
                                state_q[i] = cth_pkg::ST_CLOSED;
                                add(cth_pkg::KIND_EVENT, 1'b0, i,
                                    syn ? cth_pkg::EV_SYN_FAIL : cth_pkg::EV_FIN_FAIL,
                                    2'd0, 16'd0, 16'd0);
                            end
                        end
                    end
                default: ;
            endcase
            if (burst.size() > 0) burst[burst.size() - 1].last = 1'b1;
            foreach (burst[k]) pending.push_back(burst[k]);
        endfunction

        function void check(conn_result_t got);
            conn_result_t want;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result beat: %p", got);
                return;
            end
            want = pending.pop_front();
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result mismatch: expected %p, actual %p", want, got);
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [2:0]  cmd = 3'd0;
    logic [2:0]  slot = 3'd0;
    logic [15:0] local_port = 16'd0;
    logic [15:0] remote_port = 16'd0;
    logic [15:0] rx_dest_port = 16'd0;
    logic [2:0]  rx_seg_type = 3'd0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = 2'd0;
    logic [15:0] cfg_data = 16'd0;
    logic        done;
    logic [1:0]  out_kind;
    logic        ok;
    logic [2:0]  out_slot;
    logic [1:0]  event_code;
    logic [1:0]  tx_seg_type;
    logic [15:0] tx_src_port;
    logic [15:0] tx_dest_port;
    logic        last;

    conn_scoreboard sb = new();
    int idle_cycles = 0;
    logic [15:0] port_pool[8];

    connection_table_handshake_fsm #(.NUM_CONNECTIONS(NCONN)) uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd(cmd), .slot(slot),
        .local_port(local_port), .remote_port(remote_port), .rx_dest_port(rx_dest_port),
        .rx_seg_type(rx_seg_type), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .done(done), .out_kind(out_kind), .ok(ok),
        .out_slot(out_slot), .event_code(event_code), .tx_seg_type(tx_seg_type),
        .tx_src_port(tx_src_port), .tx_dest_port(tx_dest_port), .last(last)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                sb.check({out_kind, ok, out_slot, event_code, tx_seg_type,
                          tx_src_port, tx_dest_port, last});
            if (start && !busy)
                sb.note_input(cmd, slot, local_port, remote_port, rx_dest_port, rx_seg_type);
            if (done || (start && !busy))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("tb_connection_table_handshake_fsm: FAIL");
                $finish;
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send(logic [2:0] c, logic [2:0] s, logic [15:0] lp, logic [15:0] rp,
                        logic [15:0] dp, logic [2:0] st, int gap);
        cmd <= c;
        slot <= s;
        local_port <= lp;
        remote_port <= rp;
        rx_dest_port <= dp;
        rx_seg_type <= st;
        start <= 1'b1;
        do @(posedge clk); while (busy);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic quiesce();
        start <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() > 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_regs(logic [15:0] syn_to, logic [15:0] syn_rt,
                              logic [15:0] fin_to, logic [15:0] fin_rt);
        logic [15:0] vals[4];
        vals = '{syn_to, syn_rt, fin_to, fin_rt};
        for (int i = 0; i < 4; i++)
        begin
            cfg_we <= 1'b1;
            cfg_index <= i[1:0];
            cfg_data <= vals[i];
            @(posedge clk);
            sb.set_reg(i[1:0], vals[i]);
        end
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic random_item();
        int r;
        logic [15:0] p;
        logic [2:0] t;
        r = $urandom_range(0, 99);
        p = ($urandom_range(0, 4) == 0) ? 16'($urandom) : port_pool[$urandom_range(0, 7)];
        t = ($urandom_range(0, 4) == 0) ? 3'($urandom)
            : ($urandom_range(0, 1) ? {1'b0, cth_pkg::SEG_SYNACK}
                                    : {1'b0, cth_pkg::SEG_FINACK});
        if (r < 18)
            send(cth_pkg::CMD_OPEN, 3'($urandom), p, 16'($urandom), 16'($urandom),
                 3'($urandom), pick_gap());
        else if (r < 33)
            send(cth_pkg::CMD_CONNECT, 3'($urandom), 16'($urandom), 16'($urandom),
                 16'($urandom), 3'($urandom), pick_gap());
        else if (r < 43)
            send(cth_pkg::CMD_DISCONNECT, 3'($urandom), 16'($urandom), 16'($urandom),
                 16'($urandom), 3'($urandom), pick_gap());
        else if (r < 52)
            send(cth_pkg::CMD_CLOSE, 3'($urandom), 16'($urandom), 16'($urandom),
                 16'($urandom), 3'($urandom), pick_gap());
        else if (r < 75)
            send(cth_pkg::CMD_RX, 3'($urandom), 16'($urandom), 16'($urandom), p, t,
                 pick_gap());
        else if (r < 97)
            send(cth_pkg::CMD_TICK, 3'($urandom), 16'($urandom), 16'($urandom),
                 16'($urandom), 3'($urandom), pick_gap());
        else
            send(3'($urandom_range(6, 7)), 3'($urandom), 16'($urandom), 16'($urandom),
                 16'($urandom), 3'($urandom), pick_gap());
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send(cth_pkg::CMD_OPEN, 3'd0, 16'h0000, 16'd0, 16'd0, 3'd0, 0);
        send(cth_pkg::CMD_OPEN, 3'd0, 16'hFFFF, 16'd0, 16'd0, 3'd0, 1);
        send(cth_pkg::CMD_OPEN, 3'd0, 16'h0000, 16'd0, 16'd0, 3'd0, 0);
        send(cth_pkg::CMD_CONNECT, 3'd0, 16'd0, 16'hFFFF, 16'd0, 3'd0, 0);
        send(cth_pkg::CMD_CONNECT, 3'd0, 16'd0, 16'h1234, 16'd0, 3'd0, 2);
        send(cth_pkg::CMD_RX, 3'd0, 16'd0, 16'd0, 16'h0000, {1'b0, cth_pkg::SEG_SYN}, 0);
        send(cth_pkg::CMD_RX, 3'd0, 16'd0, 16'd0, 16'h0000, {1'b0, cth_pkg::SEG_SYNACK}, 0);
        send(cth_pkg::CMD_DISCONNECT, 3'd1, 16'd0, 16'd0, 16'd0, 3'd0, 0);
        send(cth_pkg::CMD_DISCONNECT, 3'd0, 16'd0, 16'd0, 16'd0, 3'd0, 0);
        send(cth_pkg::CMD_RX, 3'd0, 16'd0, 16'd0, 16'h0000, 3'd7, 0);
        send(cth_pkg::CMD_RX, 3'd0, 16'd0, 16'd0, 16'h0000, {1'b0, cth_pkg::SEG_FINACK}, 3);
        send(cth_pkg::CMD_CLOSE, 3'd0, 16'd0, 16'd0, 16'd0, 3'd0, 0);
        send(cth_pkg::CMD_CLOSE, 3'd0, 16'd0, 16'd0, 16'd0, 3'd0, 0);
        send(cth_pkg::CMD_CLOSE, 3'd7, 16'd0, 16'd0, 16'd0, 3'd0, 0);
        send(cth_pkg::CMD_CONNECT, 3'd7, 16'd0, 16'd1, 16'd0, 3'd0, 0);
        send(cth_pkg::CMD_TICK, 3'd0, 16'd0, 16'd0, 16'd0, 3'd0, 0);
        send(3'd6, 3'd0, 16'd0, 16'd0, 16'd0, 3'd0, 0);
        send(3'd7, 3'd0, 16'd0, 16'd0, 16'd0, 3'd0, 0);
        for (int i = 0; i < 8; i++)
            send(cth_pkg::CMD_OPEN, 3'd0, 16'(i + 16'h00A0), 16'd0, 16'd0, 3'd0, 0);
        quiesce();

        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: write_regs(16'd1, 16'd1, 16'd1, 16'd1);
                1: write_regs(16'hFFFF, 16'd15, 16'hFFFF, 16'd15);
                2: write_regs(16'($urandom_range(1, 4)), 16'($urandom_range(1, 3)),
                              16'($urandom_range(1, 4)), 16'($urandom_range(1, 3)));
                default: write_regs(16'($urandom_range(1, 12)), 16'($urandom_range(1, 15)),
                                    16'($urandom_range(1, 12)), 16'($urandom_range(1, 15)));
            endcase
            port_pool[0] = 16'h0000;
            port_pool[1] = 16'hFFFF;
            for (int i = 2; i < 8; i++) port_pool[i] = 16'($urandom);
            for (int n = 0; n < 52; n++) random_item();
            quiesce();
        end

        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("tb_connection_table_handshake_fsm: PASS");
        else
            $display("tb_connection_table_handshake_fsm: FAIL");
        $finish;
    end

endmodule
